// ===== rtl/core/pse_pkg.sv =====
// Package for the power series evaluator.
// Holds shared constants, status codes, sequencer states and the
// request/response structs of the shared multiply-divide unit.
package pse_pkg;

  localparam int unsigned PSE_MAX_TERMS_DEF = 256;
  localparam int unsigned EPS_W = 48;
  localparam logic [EPS_W-1:0] EPS_RESET = 48'd4295;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_DOMAIN = 2'd1;
  localparam logic [1:0] STAT_LIMIT  = 2'd2;
  localparam logic [1:0] STAT_OVF    = 2'd3;

  // Series select codes
  localparam logic [1:0] MODE_EXP  = 2'd0;
  localparam logic [1:0] MODE_COS  = 2'd1;
  localparam logic [1:0] MODE_CUBE = 2'd2;
  localparam logic [1:0] MODE_DFAC = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_COEF_A,
    ST_COEF_B,
    ST_MD_RUN,
    ST_ADD,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
    logic        ovf;
  } md_rsp_t;

endpackage

// ===== rtl/core/pse_in_if.sv =====
// Channel interfaces of the power series evaluator.
// Depends on pse_pkg for the eps width.
interface pse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [31:0] x_arg;
  modport source (output valid, output mode, output x_arg, input ready);
  modport sink (input valid, input mode, input x_arg, output ready);
endinterface

interface pse_out_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] sum_value;
  logic [1:0]  status;
  modport source (output valid, output sum_value, output status, input ready);
  modport sink (input valid, input sum_value, input status, output ready);
endinterface

interface pse_cfg_if
  import pse_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/power_series_evaluator.sv =====
// Power series evaluator, top level.
// Sequences the term-ratio recurrence over the shared unit pse_muldiv.
// Depends on pse_pkg and the channel interfaces in pse_in_if.sv.
//
// Usage:
//   in_ch  carries mode and x_arg (signed Q16.16); a transaction is taken
//          only while the block is idle.
//   out_ch carries sum_value (signed Q32.32) and status, one result per input.
//   cfg_ch writes eps (unsigned Q16.32); always ready, write it while idle.
// Sequence: a domain error goes from idle straight to the done state. Otherwise each
//   term runs a loop check, two coefficient states, an add state and one (modes 0, 1)
//   or two (modes 2, 3) passes of the multiply-divide unit, each pass a request, a
//   partial-product multiply, a restoring divide and a response, with up to
//   MAX_TERMS-1 terms per transaction. The 128-step divider sets the rate.
// Reset: eps returns to 4295, the sequencer idles, no result is pending.
// Stall: a finished result is held in the output register; the next
//   transaction is accepted meanwhile, and its own result waits in the
//   sequencer until the output register frees up.
module power_series_evaluator
  import pse_pkg::*;
#(
  parameter int unsigned MAX_TERMS = PSE_MAX_TERMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  pse_in_if.sink         in_ch,
  pse_out_if.source      out_ch,
  pse_cfg_if.sink        cfg_ch
);

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned KW = $clog2(MAX_TERMS);
  localparam int unsigned SW = KW + 2;

  seq_state_t       state_r, state_nxt;
  logic [EPS_W-1:0] eps_r;
  logic [1:0]       mode_r, mode_nxt;
  logic             xneg_r, xneg_nxt;
  logic [31:0]      ax_r, ax_nxt;
  logic [63:0]      x2_r, x2_nxt;
  logic [63:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [63:0]      sum_r, sum_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             phase_r, phase_nxt;
  logic [2*SW-1:0]  pa_r, pa_nxt, pb_r, pb_nxt;
  md_req_t          md_req_r, md_req_nxt;
  md_rsp_t          md_rsp;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_sum_r, out_sum_nxt;
  logic [1:0]       out_stat_r, out_stat_nxt;

  logic [CW-1:0]    k_full;
  logic [KW-1:0]    k;
  logic [SW-1:0]    sm_a, sm_b;
  logic [2*SW-1:0]  sm_p;
  logic [31:0]      in_ax;
  logic             in_neg, dom_err;
  logic [64:0]      sum_ext;
  logic             add_ovf, new_neg;

  pse_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req_r),
    .rsp   (md_rsp)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sum_value = out_sum_r;
  assign out_ch.status    = out_stat_r;

  // Input decode: magnitude and domain check
  always_comb begin
    in_neg  = in_ch.x_arg[31];
    in_ax   = in_neg ? (32'd0 - in_ch.x_arg) : in_ch.x_arg;
    dom_err = ((in_ch.mode == MODE_CUBE) && !in_neg && (in_ch.x_arg >= ONE_Q16)) ||
              ((in_ch.mode == MODE_DFAC) && !in_neg && (in_ch.x_arg > ONE_Q16));
  end

  // Term index and the small coefficient multiplier
  always_comb begin
    k_full = count_r - CW'(1);
    k      = k_full[KW-1:0];
    if (state_r == ST_COEF_A) begin
      if (mode_r == MODE_COS) begin
        sm_a = SW'({k, 1'b1});
        sm_b = SW'({k, 1'b0}) + SW'(2);
      end else begin
        sm_a = SW'(k) + SW'(1);
        sm_b = SW'(k) + SW'(1);
      end
    end else begin
      sm_a = SW'(3) * SW'(k) + SW'(1);
      sm_b = SW'(3) * SW'(k) + SW'(2);
    end
    sm_p = (2*SW)'(sm_a) * (2*SW)'(sm_b);
  end

  // Accumulate the new term with range check
  always_comb begin
    sum_ext = neg_r ? ({sum_r[63], sum_r} - {1'b0, mag_r})
                    : ({sum_r[63], sum_r} + {1'b0, mag_r});
    add_ovf = (sum_ext[64] != sum_ext[63]);
    unique case (mode_r)
      MODE_EXP:  new_neg = neg_r ^ xneg_r;
      MODE_CUBE: new_neg = neg_r;
      default:   new_neg = ~neg_r;
    endcase
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    xneg_nxt      = xneg_r;
    ax_nxt        = ax_r;
    x2_nxt        = x2_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sum_nxt       = sum_r;
    stat_nxt      = stat_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    md_req_nxt    = md_req_r;
    md_req_nxt.start = 1'b0;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_stat_nxt  = out_stat_r;

    // Drop the result once taken
    if (out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          xneg_nxt  = in_neg;
          ax_nxt    = in_ax;
          x2_nxt    = 64'(in_ax) * 64'(in_ax);
          mag_nxt   = ONE_Q32;
          neg_nxt   = 1'b0;
          count_nxt = CW'(1);
          if (dom_err) begin
            sum_nxt   = '0;
            stat_nxt  = STAT_DOMAIN;
            state_nxt = ST_DONE;
          end else begin
            sum_nxt   = ONE_Q32;
            stat_nxt  = STAT_OK;
            state_nxt = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (mag_r < 64'(eps_r)) begin
          state_nxt = ST_DONE;
        end else if (count_r >= CW'(MAX_TERMS)) begin
          stat_nxt  = STAT_LIMIT;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_COEF_A;
        end
      end
      ST_COEF_A: begin
        pa_nxt    = sm_p;
        state_nxt = ST_COEF_B;
      end
      ST_COEF_B: begin
        pb_nxt           = sm_p;
        phase_nxt        = 1'b0;
        md_req_nxt.start = 1'b1;
        md_req_nxt.a     = mag_r;
        unique case (mode_r)
          MODE_EXP: begin
            md_req_nxt.b = 64'(ax_r);
            md_req_nxt.d = 64'(k) + 64'd1 << 16;
          end
          MODE_COS: begin
            md_req_nxt.b = x2_r;
            md_req_nxt.d = 64'(pa_r) << 32;
          end
          default: begin
            md_req_nxt.b = x2_r;
            md_req_nxt.d = ONE_Q32;
          end
        endcase
        state_nxt = ST_MD_RUN;
      end
      ST_MD_RUN: begin
        if (md_rsp.done) begin
          if (mode_r[1] && !phase_r) begin
            if (md_rsp.ovf) begin
              // Overflow in the x^2 step; the sign still flips for mode 3
              sum_nxt   = new_neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
              neg_nxt   = new_neg;
              stat_nxt  = STAT_OVF;
              state_nxt = ST_DONE;
            end else begin
              phase_nxt        = 1'b1;
              md_req_nxt.start = 1'b1;
              md_req_nxt.a     = md_rsp.q;
              if (mode_r == MODE_CUBE) begin
                md_req_nxt.b = 64'(pa_r) + (64'(pa_r) << 3);
                md_req_nxt.d = 64'(pb_r);
              end else begin
                md_req_nxt.b = 64'({k, 1'b1});
                md_req_nxt.d = 64'({k, 1'b0}) + 64'd2;
              end
            end
          end else begin
            neg_nxt = new_neg;
            if (md_rsp.ovf || md_rsp.q[63]) begin
              sum_nxt   = new_neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
              stat_nxt  = STAT_OVF;
              state_nxt = ST_DONE;
            end else begin
              mag_nxt   = md_rsp.q;
              state_nxt = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        if (add_ovf) begin
          sum_nxt   = neg_r ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          stat_nxt  = STAT_OVF;
          state_nxt = ST_DONE;
        end else begin
          sum_nxt   = sum_ext[63:0];
          count_nxt = count_r + CW'(1);
          state_nxt = ST_LOOP;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      md_req_r.start <= 1'b0;
      eps_r          <= EPS_RESET;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      md_req_r       <= md_req_nxt;
      if (cfg_ch.valid) eps_r <= cfg_ch.data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    xneg_r       <= xneg_nxt;
    ax_r         <= ax_nxt;
    x2_r         <= x2_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    sum_r        <= sum_nxt;
    stat_r       <= stat_nxt;
    count_r      <= count_nxt;
    phase_r      <= phase_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    out_sum_r    <= out_sum_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  // A domain error always reports a zero sum
  a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == STAT_DOMAIN) |-> (out_sum_r == 64'd0))
    else $error("domain error with nonzero sum");

  // The shared unit only answers while the sequencer waits on it
  a_md_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == ST_MD_RUN))
    else $error("muldiv done outside wait state");

  // A start is issued only while the sequencer is in the wait state
  a_md_start: assert property (@(posedge clk) disable iff (!rst_n)
    md_req_r.start |-> (state_r == ST_MD_RUN))
    else $error("muldiv start without wait state");

endmodule

// ===== rtl/core/pse_muldiv.sv =====
// Shared multiply-divide unit: q = floor(a*b/d), flags a quotient above 64 bits.
// Multiplies in four 32x32 partial products, then divides one bit a cycle.
// Depends on pse_pkg.
module pse_muldiv
  import pse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_state_t    state_r;
  logic [63:0]  a_r, b_r, d_r;
  logic [127:0] acc_r;
  logic [63:0]  rem_r, q_r;
  logic         ovf_r, done_r;
  logic [1:0]   mcnt_r;
  logic [6:0]   dcnt_r;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  rem_ext, rem_diff;
  logic         ge;

  // Select the partial product and its weight
  always_comb begin
    a_half = mcnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_half = mcnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp     = 64'(a_half) * 64'(b_half);
    case (2'(mcnt_r[1]) + 2'(mcnt_r[0]))
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
  end

  // One restoring division step
  always_comb begin
    rem_ext  = {rem_r, acc_r[127]};
    rem_diff = rem_ext - {1'b0, d_r};
    ge       = (rem_ext >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MD_IDLE: begin
          if (req.start) begin
            a_r     <= req.a;
            b_r     <= req.b;
            d_r     <= req.d;
            acc_r   <= '0;
            mcnt_r  <= '0;
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          acc_r  <= acc_r + pp_sh;
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) begin
            rem_r   <= '0;
            q_r     <= '0;
            ovf_r   <= 1'b0;
            dcnt_r  <= '0;
            state_r <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem_r  <= ge ? rem_diff[63:0] : rem_ext[63:0];
          q_r    <= {q_r[62:0], ge};
          if (ge && !dcnt_r[6]) ovf_r <= 1'b1;
          acc_r  <= {acc_r[126:0], 1'b0};
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'd127) begin
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.ovf  = ovf_r;

endmodule
